// ===== sv/rds_pkg.sv =====
package rds_pkg;

  localparam int WW = 128;
  localparam int DIG = 8;
  localparam int XW = 24;
  localparam int CVW = 15;
  localparam int TABLE_ENTRIES = 20;
  localparam int T_TABLE_DEPTH = 20;
  localparam int TABLE_LIM = (T_TABLE_DEPTH < TABLE_ENTRIES) ? T_TABLE_DEPTH : TABLE_ENTRIES;

  localparam logic [CVW-1:0] CRIT_ONE [TABLE_ENTRIES] = '{
    15'd31821, 15'd6965, 15'd4541, 15'd3747, 15'd3365, 15'd3143, 15'd2998, 15'd2896,
    15'd2821, 15'd2764, 15'd2718, 15'd2681, 15'd2650, 15'd2624, 15'd2602, 15'd2583,
    15'd2567, 15'd2552, 15'd2539, 15'd2528};
  localparam logic [CVW-1:0] CRIT_FIVE [TABLE_ENTRIES] = '{
    15'd6314, 15'd2920, 15'd2353, 15'd2132, 15'd2015, 15'd1943, 15'd1895, 15'd1860,
    15'd1833, 15'd1812, 15'd1796, 15'd1782, 15'd1771, 15'd1761, 15'd1753, 15'd1746,
    15'd1740, 15'd1734, 15'd1729, 15'd1725};
  localparam logic [CVW-1:0] LIMIT_ONE = 15'd2326;
  localparam logic [CVW-1:0] LIMIT_FIVE = 15'd1645;
  localparam logic [19:0] MILLION = 20'd1000000;

  localparam logic [1:0] ORD_LESS = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_THIN = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

endpackage

// ===== sv/rds_mul.sv =====
module rds_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rds_pkg::WW-1:0] opa,
  input  logic [rds_pkg::WW-1:0] opb,
  output logic                   done,
  output logic [rds_pkg::WW-1:0] product
);

  logic [rds_pkg::WW-1:0] a;
  logic [rds_pkg::WW-1:0] b;
  logic [rds_pkg::WW-1:0] acc;
  logic                   busy;
  logic [rds_pkg::WW-1:0] part;

  // one radix-256 digit of the multiplier per cycle
  assign part = a * rds_pkg::WW'(b[rds_pkg::DIG-1:0]);
  assign done = busy && (b == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= opa;
      b <= opb;
      acc <= '0;
    end else if (busy && (b != '0)) begin
      acc <= acc + part;
      a <= a << rds_pkg::DIG;
      b <= b >> rds_pkg::DIG;
    end
  end

endmodule

// ===== sv/rollout_dominance_screen.sv =====
// Screens a candidate against an incumbent from streamed rollout objectives (signed Q12.12
// in s_tdata). Each word adds one sample to the set chosen by s_tuser, unless that set is
// full, after an optional clear, and returns one result word: after a candidate sample
// with at least two incumbent samples it runs one-sided Student-t tests (prediction bound
// at 1 percent, then mean bound at 5 percent) exactly in 128-bit integers. All products
// go through one shared multiplier that takes one 8-bit digit of its second operand per
// cycle. The input is not ready while an item is processed, while a finished result may
// still wait in the output register.
module rollout_dominance_screen #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // objective
  input  logic [2:0]  s_tuser,   // to_candidate, clear_first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // dominated, assessed, mean_order, status
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = rds_pkg::XW + CW - 1;
  localparam int QW = 2 * rds_pkg::XW - 1 + CW - 1;
  localparam int WW = rds_pkg::WW;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_UPD  = 5'd1;
  localparam logic [4:0] ST_ORD1 = 5'd2;
  localparam logic [4:0] ST_ORD2 = 5'd3;
  localparam logic [4:0] ST_A1   = 5'd4;
  localparam logic [4:0] ST_A2   = 5'd5;
  localparam logic [4:0] ST_A3   = 5'd6;
  localparam logic [4:0] ST_A4   = 5'd7;
  localparam logic [4:0] ST_A5   = 5'd8;
  localparam logic [4:0] ST_A6   = 5'd9;
  localparam logic [4:0] ST_A7   = 5'd10;
  localparam logic [4:0] ST_A8   = 5'd11;
  localparam logic [4:0] ST_A9   = 5'd12;
  localparam logic [4:0] ST_B1   = 5'd13;
  localparam logic [4:0] ST_B2   = 5'd14;
  localparam logic [4:0] ST_B3   = 5'd15;
  localparam logic [4:0] ST_B4   = 5'd16;
  localparam logic [4:0] ST_B5   = 5'd17;
  localparam logic [4:0] ST_B6   = 5'd18;
  localparam logic [4:0] ST_B7   = 5'd19;
  localparam logic [4:0] ST_B8   = 5'd20;
  localparam logic [4:0] ST_B9   = 5'd21;
  localparam logic [4:0] ST_B10  = 5'd22;
  localparam logic [4:0] ST_B11  = 5'd23;
  localparam logic [4:0] ST_DONE = 5'd24;

  logic [4:0]        st;
  logic              phase;
  logic [CW-1:0]     inc_cnt;
  logic [SW-1:0]     inc_sum;
  logic [QW-1:0]     inc_sq;
  logic [CW-1:0]     cand_cnt;
  logic [SW-1:0]     cand_sum;
  logic [QW-1:0]     cand_sq;
  logic [rds_pkg::XW-1:0] cand_last;
  logic [rds_pkg::XW-1:0] x_in;
  logic              toc;
  logic [1:0]        clr;
  logic              run;
  logic              dominated;
  logic [1:0]        order;
  logic [1:0]        status;
  logic [WW-1:0]     r1;
  logic [WW-1:0]     r2;
  logic [WW-1:0]     r3;

  logic              mul_start;
  logic              mul_done;
  logic [WW-1:0]     opa;
  logic [WW-1:0]     opb;
  logic [WW-1:0]     acc;

  // update values
  logic [CW-1:0]     ic0;
  logic [SW-1:0]     is0;
  logic [QW-1:0]     iq0;
  logic [CW-1:0]     cc0;
  logic [SW-1:0]     cs0;
  logic [QW-1:0]     cq0;
  logic              drop;
  logic [rds_pkg::XW-1:0] xm;
  logic [2*rds_pkg::XW-1:0] xsq;
  logic [SW-1:0]     xs;

  // operand views
  logic [WW-1:0]     si_x;
  logic [WW-1:0]     sc_x;
  logic [WW-1:0]     last_x;
  logic [SW-1:0]     si_m;
  logic [SW-1:0]     sc_m;
  logic [WW-1:0]     kz;
  logic [WW-1:0]     nz;
  logic [31:0]       df_k;
  logic [31:0]       df_n;
  logic [rds_pkg::CVW-1:0] t_one;
  logic [rds_pkg::CVW-1:0] t_five;
  logic              skip_ord;
  logic [WW-1:0]     diff;
  logic [WW-1:0]     clamp;

  assign s_tready = (st == ST_IDLE);

  always_comb begin
    ic0 = clr[1] ? '0 : inc_cnt;
    is0 = clr[1] ? '0 : inc_sum;
    iq0 = clr[1] ? '0 : inc_sq;
    cc0 = clr[0] ? '0 : cand_cnt;
    cs0 = clr[0] ? '0 : cand_sum;
    cq0 = clr[0] ? '0 : cand_sq;
    drop = toc ? (32'(cc0) >= MAX_SAMPLES) : (32'(ic0) >= MAX_SAMPLES);
    xm = x_in[rds_pkg::XW-1] ? (~x_in + 1'b1) : x_in;
    xsq = xm * xm;
    xs = {{(SW-rds_pkg::XW){x_in[rds_pkg::XW-1]}}, x_in};
  end

  always_comb begin
    si_x = {{(WW-SW){inc_sum[SW-1]}}, inc_sum};
    sc_x = {{(WW-SW){cand_sum[SW-1]}}, cand_sum};
    last_x = {{(WW-rds_pkg::XW){cand_last[rds_pkg::XW-1]}}, cand_last};
    si_m = inc_sum[SW-1] ? (~inc_sum + 1'b1) : inc_sum;
    sc_m = cand_sum[SW-1] ? (~cand_sum + 1'b1) : cand_sum;
    kz = WW'(inc_cnt);
    nz = WW'(cand_cnt);
    df_k = 32'(inc_cnt) - 32'd1;
    df_n = 32'(cand_cnt) - 32'd1;
    t_one = ((df_k != 0) && (df_k <= 32'(rds_pkg::TABLE_LIM)))
          ? rds_pkg::CRIT_ONE[5'(df_k - 32'd1)] : rds_pkg::LIMIT_ONE;
    t_five = ((df_n != 0) && (df_n <= 32'(rds_pkg::TABLE_LIM)))
           ? rds_pkg::CRIT_FIVE[5'(df_n - 32'd1)] : rds_pkg::LIMIT_FIVE;
    skip_ord = (inc_cnt == '0) || (cand_cnt == '0);
    diff = r2 - acc;
    clamp = (r1 < acc) ? '0 : (r1 - acc);
  end

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (st)
      ST_ORD1: begin opa = sc_x; opb = kz; end
      ST_ORD2: begin opa = si_x; opb = nz; end
      ST_A1:   begin opa = WW'(inc_sq); opb = kz; end
      ST_A2:   begin opa = WW'(si_m); opb = WW'(si_m); end
      ST_A3:   begin opa = last_x; opb = kz; end
      ST_A4:   begin opa = r2; opb = r2; end
      ST_A5:   begin opa = r2; opb = kz - 1'b1; end
      ST_A6:   begin opa = r2; opb = WW'(rds_pkg::MILLION); end
      ST_A7:   begin opa = WW'(t_one); opb = WW'(t_one); end
      ST_A8:   begin opa = r3; opb = kz + 1'b1; end
      ST_A9:   begin opa = r1; opb = r3; end
      ST_B1:   begin opa = WW'(cand_sq); opb = nz; end
      ST_B2:   begin opa = WW'(sc_m); opb = WW'(sc_m); end
      ST_B3:   begin opa = si_x; opb = nz; end
      ST_B4:   begin opa = sc_x; opb = kz; end
      ST_B5:   begin opa = r2; opb = r2; end
      ST_B6:   begin opa = r2; opb = nz - 1'b1; end
      ST_B7:   begin opa = r2; opb = WW'(rds_pkg::MILLION); end
      ST_B8:   begin opa = WW'(t_five); opb = WW'(t_five); end
      ST_B9:   begin opa = r3; opb = kz; end
      ST_B10:  begin opa = r3; opb = kz; end
      ST_B11:  begin opa = r1; opb = r3; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign mul_start = !phase && (st >= ST_ORD1) && (st <= ST_B11)
                   && !((st == ST_ORD1) && skip_ord);

  rds_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .opa     (opa),
    .opb     (opb),
    .done    (mul_done),
    .product (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      phase <= 1'b0;
      inc_cnt <= '0;
      inc_sum <= '0;
      inc_sq <= '0;
      cand_cnt <= '0;
      cand_sum <= '0;
      cand_sq <= '0;
      cand_last <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (st != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (mul_start) begin
        phase <= 1'b1;
      end
      unique case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            x_in <= s_tdata;
            toc <= s_tuser[0];
            clr <= s_tuser[2:1];
            st <= ST_UPD;
          end
        end
        ST_UPD: begin
          inc_cnt <= (drop || toc) ? ic0 : ic0 + 1'b1;
          inc_sum <= (drop || toc) ? is0 : is0 + xs;
          inc_sq <= (drop || toc) ? iq0 : iq0 + QW'(xsq);
          cand_cnt <= (drop || !toc) ? cc0 : cc0 + 1'b1;
          cand_sum <= (drop || !toc) ? cs0 : cs0 + xs;
          cand_sq <= (drop || !toc) ? cq0 : cq0 + QW'(xsq);
          if (!drop && toc) begin
            cand_last <= x_in;
          end
          dominated <= 1'b0;
          run <= !drop && toc && (32'(ic0) >= 32'd2);
          if (drop) begin
            status <= rds_pkg::STAT_FULL;
          end else if (toc && (32'(ic0) < 32'd2)) begin
            status <= rds_pkg::STAT_THIN;
          end else begin
            status <= rds_pkg::STAT_OK;
          end
          st <= ST_ORD1;
        end
        ST_ORD1: begin
          if (skip_ord) begin
            if ((inc_cnt == '0) && (cand_cnt == '0)) begin
              order <= rds_pkg::ORD_EQUAL;
            end else if (cand_cnt == '0) begin
              order <= rds_pkg::ORD_LESS;
            end else begin
              order <= rds_pkg::ORD_GREATER;
            end
            st <= run ? ST_A1 : ST_DONE;
          end else if (mul_done) begin
            r1 <= acc;
            phase <= 1'b0;
            st <= ST_ORD2;
          end
        end
        ST_ORD2: begin
          if (mul_done) begin
            phase <= 1'b0;
            if ($signed(r1) < $signed(acc)) begin
              order <= rds_pkg::ORD_LESS;
            end else if (r1 == acc) begin
              order <= rds_pkg::ORD_EQUAL;
            end else begin
              order <= rds_pkg::ORD_GREATER;
            end
            st <= run ? ST_A1 : ST_DONE;
          end
        end
        ST_A1, ST_B1: begin
          if (mul_done) begin
            r1 <= acc;
            phase <= 1'b0;
            st <= st + 1'b1;
          end
        end
        ST_A2, ST_B2: begin
          if (mul_done) begin
            r1 <= clamp;
            phase <= 1'b0;
            st <= st + 1'b1;
          end
        end
        ST_A3: begin
          if (mul_done) begin
            phase <= 1'b0;
            r2 <= si_x - acc;
            if ($signed(si_x - acc) > 0) begin
              st <= ST_A4;
            end else begin
              st <= (cand_cnt >= CW'(2)) ? ST_B1 : ST_DONE;
            end
          end
        end
        ST_B3: begin
          if (mul_done) begin
            r2 <= acc;
            phase <= 1'b0;
            st <= ST_B4;
          end
        end
        ST_B4: begin
          if (mul_done) begin
            phase <= 1'b0;
            r2 <= diff;
            st <= ($signed(diff) > 0) ? ST_B5 : ST_DONE;
          end
        end
        ST_A4, ST_A5, ST_A6, ST_B5, ST_B6, ST_B7: begin
          if (mul_done) begin
            r2 <= acc;
            phase <= 1'b0;
            st <= st + 1'b1;
          end
        end
        ST_A7, ST_A8, ST_B8, ST_B9, ST_B10: begin
          if (mul_done) begin
            r3 <= acc;
            phase <= 1'b0;
            st <= st + 1'b1;
          end
        end
        ST_A9: begin
          if (mul_done) begin
            phase <= 1'b0;
            if (acc < r2) begin
              dominated <= 1'b1;
              st <= ST_DONE;
            end else begin
              st <= (cand_cnt >= CW'(2)) ? ST_B1 : ST_DONE;
            end
          end
        end
        ST_B11: begin
          if (mul_done) begin
            phase <= 1'b0;
            if (acc < r2) begin
              dominated <= 1'b1;
            end
            st <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {2'b00, status, order, run, dominated};
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_update: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (st == ST_UPD))
    else $error("accepted word did not start an update");

  a_dominated_needs_assessed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[0] || (m_tdata[1] && (m_tdata[5:4] == rds_pkg::STAT_OK))))
    else $error("dominated without a completed screen");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (32'(inc_cnt) <= MAX_SAMPLES) && (32'(cand_cnt) <= MAX_SAMPLES))
    else $error("sample count beyond limit");
`endif

endmodule
